// File: src/wide_line_rasterizer_defines.svh
// Assertion macros for the wide line rasterizer.
`ifndef WIDE_LINE_RASTERIZER_DEFINES_SVH
`define WIDE_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define WLR_ASSERT_NOW(name, trig, chk, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (chk)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define WLR_ASSERT_NEXT(name, trig, chk, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (chk)) \
    else $error(msg);

`endif

// File: src/wlr_pkg.sv
// Shared constants and configuration register map for the wide line rasterizer.
package wlr_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int COLOR_BITS     = 4;
  localparam int PEN_WIDTH_BITS = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_END_X     = 3'd2,
    REG_END_Y     = 3'd3,
    REG_PEN_COLOR = 3'd4,
    REG_PEN_WIDTH = 3'd5
  } cfg_reg_t;

  // direction of the minor coordinate along a line
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd3
  } minor_step_t;

  localparam logic [COLOR_BITS-1:0]     PEN_COLOR_RESET = 4'd15;
  localparam logic [PEN_WIDTH_BITS-1:0] PEN_WIDTH_RESET = 5'd1;

endpackage

// File: src/wlr_cfg_regs.sv
// Configuration registers: endpoints, pen color and pen width.
module wlr_cfg_regs #(
  parameter int COORD_BITS = 11
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wlr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wlr_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic signed [COORD_BITS-1:0]           start_x,
  output logic signed [COORD_BITS-1:0]           start_y,
  output logic signed [COORD_BITS-1:0]           end_x,
  output logic signed [COORD_BITS-1:0]           end_y,
  output logic [wlr_pkg::COLOR_BITS-1:0]         pen_color,
  output logic [wlr_pkg::PEN_WIDTH_BITS-1:0]     pen_width
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      end_x     <= '0;
      end_y     <= '0;
      pen_color <= wlr_pkg::PEN_COLOR_RESET;
      pen_width <= wlr_pkg::PEN_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wlr_pkg::REG_START_X:   start_x   <= cfg_data[COORD_BITS-1:0];
        wlr_pkg::REG_START_Y:   start_y   <= cfg_data[COORD_BITS-1:0];
        wlr_pkg::REG_END_X:     end_x     <= cfg_data[COORD_BITS-1:0];
        wlr_pkg::REG_END_Y:     end_y     <= cfg_data[COORD_BITS-1:0];
        wlr_pkg::REG_PEN_COLOR: pen_color <= cfg_data[wlr_pkg::COLOR_BITS-1:0];
        wlr_pkg::REG_PEN_WIDTH: pen_width <= cfg_data[wlr_pkg::PEN_WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/wlr_stepper.sv
// Bresenham line state: loads a line, steps one major position per item.
module wlr_stepper #(
  parameter int COORD_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_take,
  input  logic                          begin_line,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  output logic                          span_load,
  output logic signed [COORD_BITS-1:0]  span_major,
  output logic signed [COORD_BITS-1:0]  span_minor,
  output logic signed [COORD_BITS-1:0]  span_end,
  output logic                          span_x_major
);

  localparam int CB = COORD_BITS;
  localparam int AB = COORD_BITS + 1;

  // Line state holds the position of the last span sent out.
  logic signed [CB-1:0] major_pos, minor_pos, major_end;
  logic [CB-1:0]        major_delta, minor_delta;
  logic [AB-1:0]        error_acc;
  wlr_pkg::minor_step_t minor_step;
  logic                 x_is_major;
  logic                 line_active;

  // Load path
  logic signed [CB:0]   diff_x, diff_y, neg_x, neg_y;
  logic [CB-1:0]        dx, dy;
  logic                 ld_xmaj, ld_swap;
  logic signed [CB-1:0] ma0, ma1, mi0, mi1;
  logic signed [CB-1:0] ld_major, ld_end, ld_minor, ld_minor_end;
  wlr_pkg::minor_step_t ld_step;
  logic [CB-1:0]        ld_major_delta, ld_minor_delta;

  // Advance path
  logic                 at_end;
  logic [AB-1:0]        acc_sum;
  logic                 acc_hit;
  logic signed [CB-1:0] adv_major, adv_minor;
  logic [AB-1:0]        adv_acc;

  always_comb begin
    diff_x = {start_x[CB-1], start_x} - {end_x[CB-1], end_x};
    diff_y = {start_y[CB-1], start_y} - {end_y[CB-1], end_y};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    dx     = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
    dy     = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];

    ld_xmaj = dy < dx;
    ma0 = ld_xmaj ? start_x : start_y;
    ma1 = ld_xmaj ? end_x   : end_y;
    mi0 = ld_xmaj ? start_y : start_x;
    mi1 = ld_xmaj ? end_y   : end_x;
    ld_swap      = ma0 > ma1;
    ld_major     = ld_swap ? ma1 : ma0;
    ld_end       = ld_swap ? ma0 : ma1;
    ld_minor     = ld_swap ? mi1 : mi0;
    ld_minor_end = ld_swap ? mi0 : mi1;
    if (ld_minor_end > ld_minor) begin
      ld_step = wlr_pkg::STEP_UP;
    end else if (ld_minor_end < ld_minor) begin
      ld_step = wlr_pkg::STEP_DOWN;
    end else begin
      ld_step = wlr_pkg::STEP_NONE;
    end
    ld_major_delta = ld_xmaj ? dx : dy;
    ld_minor_delta = ld_xmaj ? dy : dx;

    at_end    = major_pos >= major_end;
    acc_sum   = error_acc + AB'(minor_delta);
    acc_hit   = acc_sum >= AB'(major_delta);
    adv_major = major_pos + CB'(1);
    adv_acc   = acc_hit ? acc_sum - AB'(major_delta) : acc_sum;
    adv_minor = minor_pos;
    if (acc_hit) begin
      case (minor_step)
        wlr_pkg::STEP_UP:   adv_minor = minor_pos + CB'(1);
        wlr_pkg::STEP_DOWN: adv_minor = minor_pos - CB'(1);
        default:            adv_minor = minor_pos;
      endcase
    end

    span_load    = item_take && (begin_line || (line_active && !at_end));
    span_major   = begin_line ? ld_major : adv_major;
    span_minor   = begin_line ? ld_minor : adv_minor;
    span_end     = begin_line ? ld_end   : major_end;
    span_x_major = begin_line ? ld_xmaj  : x_is_major;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos   <= '0;
      minor_pos   <= '0;
      major_end   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_acc   <= '0;
      minor_step  <= wlr_pkg::STEP_NONE;
      x_is_major  <= 1'b0;
      line_active <= 1'b0;
    end else if (item_take) begin
      if (begin_line) begin
        major_pos   <= ld_major;
        minor_pos   <= ld_minor;
        major_end   <= ld_end;
        major_delta <= ld_major_delta;
        minor_delta <= ld_minor_delta;
        error_acc   <= '0;
        minor_step  <= ld_step;
        x_is_major  <= ld_xmaj;
        line_active <= 1'b1;
      end else if (line_active) begin
        // the span at the final position has gone out: line is finished
        if (at_end) begin
          line_active <= 1'b0;
        end else begin
          major_pos <= adv_major;
          minor_pos <= adv_minor;
          error_acc <= adv_acc;
        end
      end
    end
  end

endmodule

// File: src/wlr_span_gen.sv
// Span register and pixel output register: one pen pixel per cycle unless out_ready stalls.
module wlr_span_gen #(
  parameter int COORD_BITS = 11,
  parameter int MAX_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                span_load,
  input  logic signed [COORD_BITS-1:0]        span_major,
  input  logic signed [COORD_BITS-1:0]        span_minor,
  input  logic signed [COORD_BITS-1:0]        span_end,
  input  logic                                span_x_major,
  input  logic [wlr_pkg::COLOR_BITS-1:0]      pen_color,
  input  logic [wlr_pkg::PEN_WIDTH_BITS-1:0]  pen_width,
  output logic                                span_free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS:0]          pix_x,
  output logic signed [COORD_BITS:0]          pix_y,
  output logic [wlr_pkg::COLOR_BITS-1:0]      pix_color,
  output logic                                span_last,
  output logic                                line_done
);

  localparam int CB = COORD_BITS;
  localparam int OB = COORD_BITS + 1;
  localparam int WB = $clog2(MAX_WIDTH + 1);

  logic                             span_valid;
  logic signed [CB-1:0]             sp_major, sp_minor, sp_end;
  logic                             sp_xmaj;
  logic [WB-1:0]                    sp_width;
  logic [wlr_pkg::COLOR_BITS-1:0]   sp_color;
  logic [WB-1:0]                    pix_idx;

  logic          out_free, emit, is_last, sp_done;
  logic [WB-1:0] idx_inc, mag, width_sat;
  logic [OB-1:0] mag_ext;
  logic signed [OB-1:0] off, minor_ext, major_ext, mn;

  always_comb begin
    out_free  = !out_valid || out_ready;
    emit      = span_valid && out_free;
    idx_inc   = pix_idx + WB'(1);
    is_last   = idx_inc == sp_width;
    span_free = !span_valid || (emit && is_last);

    // offsets across the line run 0, -1, +1, -2, +2, ...
    mag       = idx_inc >> 1;
    mag_ext   = OB'(mag);
    off       = pix_idx[0] ? -mag_ext : mag_ext;
    minor_ext = {sp_minor[CB-1], sp_minor};
    major_ext = {sp_major[CB-1], sp_major};
    mn        = minor_ext + off;
    sp_done   = sp_major >= sp_end;

    if (pen_width == '0) begin
      width_sat = WB'(1);
    end else if (32'(pen_width) > MAX_WIDTH) begin
      width_sat = WB'(MAX_WIDTH);
    end else begin
      width_sat = WB'(pen_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
      out_valid  <= 1'b0;
      pix_idx    <= '0;
    end else begin
      if (span_load) begin
        span_valid <= 1'b1;
      end else if (emit && is_last) begin
        span_valid <= 1'b0;
      end
      if (emit) begin
        pix_idx <= is_last ? '0 : idx_inc;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (span_load) begin
      sp_major <= span_major;
      sp_minor <= span_minor;
      sp_end   <= span_end;
      sp_xmaj  <= span_x_major;
      sp_width <= width_sat;
      sp_color <= pen_color;
    end
    if (emit) begin
      pix_x     <= sp_xmaj ? major_ext : mn;
      pix_y     <= sp_xmaj ? mn : major_ext;
      pix_color <= sp_color;
      span_last <= is_last;
      line_done <= sp_done;
    end
  end

endmodule

// File: src/wide_line_rasterizer.sv
// Wide line rasterizer top level: config registers, line stepper, span output.
// The first pixel of a span passes the span register, then the output register.
// Throughput: one pixel per cycle unless out_ready stalls; an item holds the span
//   stage for its pen width, 1 to MAX_WIDTH pixels; an item drawing none does not.
// Reset: synchronous; no line in progress, output empty, registers at reset values.
`include "wide_line_rasterizer_defines.svh"

module wide_line_rasterizer #(
  parameter int COORD_BITS = 11,
  parameter int MAX_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                begin_line,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS:0]          pix_x,
  output logic signed [COORD_BITS:0]          pix_y,
  output logic [wlr_pkg::COLOR_BITS-1:0]      pix_color,
  output logic                                span_last,
  output logic                                line_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wlr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic signed [COORD_BITS-1:0]        start_x, start_y, end_x, end_y;
  logic [wlr_pkg::COLOR_BITS-1:0]      pen_color;
  logic [wlr_pkg::PEN_WIDTH_BITS-1:0]  pen_width;

  logic                          item_take, span_load, span_free, span_x_major;
  logic signed [COORD_BITS-1:0]  span_major, span_minor, span_end;

  assign in_ready  = span_free;
  assign item_take = in_valid && in_ready;

  wlr_cfg_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .pen_color (pen_color),
    .pen_width (pen_width)
  );

  wlr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .item_take    (item_take),
    .begin_line   (begin_line),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .span_load    (span_load),
    .span_major   (span_major),
    .span_minor   (span_minor),
    .span_end     (span_end),
    .span_x_major (span_x_major)
  );

  wlr_span_gen #(
    .COORD_BITS(COORD_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_span (
    .clk          (clk),
    .rst          (rst),
    .span_load    (span_load),
    .span_major   (span_major),
    .span_minor   (span_minor),
    .span_end     (span_end),
    .span_x_major (span_x_major),
    .pen_color    (pen_color),
    .pen_width    (pen_width),
    .span_free    (span_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_color    (pix_color),
    .span_last    (span_last),
    .line_done    (line_done)
  );

  // a new line always produces a span
  `WLR_ASSERT_NOW(a_begin_emits, item_take && begin_line, span_load, "begin item drew no span")

  // pixels of one span come out back to back
  `WLR_ASSERT_NEXT(a_span_continues, out_valid && out_ready && !span_last, out_valid, "span cut short")

  // within a span the major coordinate, color and done flag hold
  `WLR_ASSERT_NEXT(a_span_uniform, out_valid && out_ready && !span_last, (line_done == $past(line_done)) && (pix_color == $past(pix_color)) && ((pix_x == $past(pix_x)) || (pix_y == $past(pix_y))), "span pixels disagree")

endmodule

// File: tb/wlr_pixel_checker.sv
// Pixel checker for the wide line rasterizer: mirrors its registers, predicts spans, compares.
`timescale 1ns / 100ps

module wlr_pixel_checker #(
  parameter int COORD_BITS = 11,
  parameter int MAX_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                begin_line,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [COORD_BITS:0]          pix_x,
  input  logic signed [COORD_BITS:0]          pix_y,
  input  logic [wlr_pkg::COLOR_BITS-1:0]      pix_color,
  input  logic                                span_last,
  input  logic                                line_done,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [wlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [wlr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  pixel_errors,
  output int                                  pixels_outstanding
);

  typedef struct packed {
    logic signed [COORD_BITS:0]     x;
    logic signed [COORD_BITS:0]     y;
    logic [wlr_pkg::COLOR_BITS-1:0] color;
    logic                           last;
    logic                           done;
  } pixel_t;

  // register mirror
  logic signed [COORD_BITS-1:0]       start_x_q, start_y_q, end_x_q, end_y_q;
  logic [wlr_pkg::COLOR_BITS-1:0]     color_q;
  logic [wlr_pkg::PEN_WIDTH_BITS-1:0] width_q;

  // stepper state
  logic signed [COORD_BITS-1:0] major_pos, minor_pos, major_end;
  logic [COORD_BITS-1:0]        major_delta, minor_delta;
  logic [COORD_BITS:0]          error_acc;
  wlr_pkg::minor_step_t         minor_step;
  logic                         x_is_major, line_active;

  pixel_t expected_pixels[$];
  int     error_count;

  task automatic rasterize_span(input logic start_new);
    int x1, y1, x2, y2, ma0, ma1, mi0, mi1, tmp;
    int w, i, off, mn, mj;
    logic [COORD_BITS-1:0] dx, dy;
    logic done;
    pixel_t px;
    if (start_new) begin
      x1 = int'(start_x_q);
      y1 = int'(start_y_q);
      x2 = int'(end_x_q);
      y2 = int'(end_y_q);
      dx = COORD_BITS'((x1 > x2) ? x1 - x2 : x2 - x1);
      dy = COORD_BITS'((y1 > y2) ? y1 - y2 : y2 - y1);
      x_is_major = dy < dx;
      if (x_is_major) begin
        ma0 = x1; ma1 = x2; mi0 = y1; mi1 = y2;
        major_delta = dx; minor_delta = dy;
      end else begin
        ma0 = y1; ma1 = y2; mi0 = x1; mi1 = x2;
        major_delta = dy; minor_delta = dx;
      end
      if (ma0 > ma1) begin
        tmp = ma0; ma0 = ma1; ma1 = tmp;
        tmp = mi0; mi0 = mi1; mi1 = tmp;
      end
      major_pos = COORD_BITS'(ma0);
      major_end = COORD_BITS'(ma1);
      minor_pos = COORD_BITS'(mi0);
      if (mi1 > mi0) begin
        minor_step = wlr_pkg::STEP_UP;
      end else if (mi1 < mi0) begin
        minor_step = wlr_pkg::STEP_DOWN;
      end else begin
        minor_step = wlr_pkg::STEP_NONE;
      end
      error_acc = '0;
      line_active = 1'b1;
    end
    if (line_active) begin
      w = int'(width_q);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      done = major_pos >= major_end;
      mj = int'(major_pos);
      // pen offsets across the line: 0, -1, +1, -2, +2, ...
      for (i = 0; i < w; i++) begin
        off = (i + 1) / 2;
        if (i % 2 == 1) off = -off;
        mn = int'(minor_pos) + off;
        if (x_is_major) begin
          px.x = mj[COORD_BITS:0];
          px.y = mn[COORD_BITS:0];
        end else begin
          px.x = mn[COORD_BITS:0];
          px.y = mj[COORD_BITS:0];
        end
        px.color = color_q;
        px.last  = (i == w - 1);
        px.done  = done;
        expected_pixels.push_back(px);
      end
      if (done) begin
        line_active = 1'b0;
      end else begin
        major_pos = major_pos + COORD_BITS'(1);
        error_acc = error_acc + (COORD_BITS + 1)'(minor_delta);
        if (error_acc >= (COORD_BITS + 1)'(major_delta)) begin
          if (minor_step == wlr_pkg::STEP_UP) begin
            minor_pos = minor_pos + COORD_BITS'(1);
          end else if (minor_step == wlr_pkg::STEP_DOWN) begin
            minor_pos = minor_pos - COORD_BITS'(1);
          end
          error_acc = error_acc - (COORD_BITS + 1)'(major_delta);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      start_x_q = '0;
      start_y_q = '0;
      end_x_q = '0;
      end_y_q = '0;
      color_q = wlr_pkg::PEN_COLOR_RESET;
      width_q = wlr_pkg::PEN_WIDTH_RESET;
      major_pos = '0;
      minor_pos = '0;
      major_end = '0;
      major_delta = '0;
      minor_delta = '0;
      error_acc = '0;
      minor_step = wlr_pkg::STEP_NONE;
      x_is_major = 1'b0;
      line_active = 1'b0;
      expected_pixels.delete();
      error_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wlr_pkg::REG_START_X:   start_x_q = cfg_data[COORD_BITS-1:0];
          wlr_pkg::REG_START_Y:   start_y_q = cfg_data[COORD_BITS-1:0];
          wlr_pkg::REG_END_X:     end_x_q = cfg_data[COORD_BITS-1:0];
          wlr_pkg::REG_END_Y:     end_y_q = cfg_data[COORD_BITS-1:0];
          wlr_pkg::REG_PEN_COLOR: color_q = cfg_data[wlr_pkg::COLOR_BITS-1:0];
          wlr_pkg::REG_PEN_WIDTH: width_q = cfg_data[wlr_pkg::PEN_WIDTH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rasterize_span(begin_line);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0b done=%0b",
                     $realtime, pix_x, pix_y, pix_color, span_last, line_done);
          end
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_x !== want.x || pix_y !== want.y || pix_color !== want.color ||
              span_last !== want.last || line_done !== want.done) begin
            if (error_count < 10) begin
              $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%0d last=%0b done=%0b",
                       $realtime, want.x, want.y, want.color, want.last, want.done);
              $display("%0t:                 got      x=%0d y=%0d color=%0d last=%0b done=%0b",
                       $realtime, pix_x, pix_y, pix_color, span_last, line_done);
            end
            error_count++;
          end
        end
      end
    end
    pixel_errors <= error_count;
    pixels_outstanding <= expected_pixels.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the wide line rasterizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_BITS  = 11;
  localparam int MAX_WIDTH   = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 185;

  // indexes past the register map; writes there must be ignored
  localparam logic [wlr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [wlr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic                                begin_line;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [COORD_BITS:0]          pix_x;
  logic signed [COORD_BITS:0]          pix_y;
  logic [wlr_pkg::COLOR_BITS-1:0]      pix_color;
  logic                                span_last;
  logic                                line_done;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [wlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
  logic [wlr_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  int pixel_errors;
  int pixels_outstanding;
  int tx_idle_pct;
  int rx_idle_pct;

  wide_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .begin_line(begin_line),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .span_last (span_last),
    .line_done (line_done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wlr_pixel_checker #(
    .COORD_BITS(COORD_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .begin_line        (begin_line),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pix_x             (pix_x),
    .pix_y             (pix_y),
    .pix_color         (pix_color),
    .span_last         (span_last),
    .line_done         (line_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pixel_errors      (pixel_errors),
    .pixels_outstanding(pixels_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ends the run when no channel moves for too long
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("testbench NOT OK");
    $finish;
  end

  task automatic send_item(input logic start_new);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    begin_line <= start_new;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, let every expected pixel drain, then allow for an empty span in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // bits above the register's width carry random noise
  task automatic write_reg(input logic [wlr_pkg::CFG_INDEX_BITS-1:0] index, input int value,
                           input int nbits);
    logic [wlr_pkg::CFG_DATA_BITS-1:0] data;
    logic [wlr_pkg::CFG_DATA_BITS-1:0] mask;
    mask = (16'd1 << nbits) - 16'd1;
    data = wlr_pkg::CFG_DATA_BITS'($urandom);
    data = (data & ~mask) | (value[wlr_pkg::CFG_DATA_BITS-1:0] & mask);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_line(input int x1, input int y1, input int x2, input int y2,
                              input int color, input int width);
    write_reg(wlr_pkg::REG_START_X, x1, COORD_BITS);
    write_reg(wlr_pkg::REG_START_Y, y1, COORD_BITS);
    write_reg(wlr_pkg::REG_END_X, x2, COORD_BITS);
    write_reg(wlr_pkg::REG_END_Y, y2, COORD_BITS);
    write_reg(wlr_pkg::REG_PEN_COLOR, color, wlr_pkg::COLOR_BITS);
    write_reg(wlr_pkg::REG_PEN_WIDTH, width, wlr_pkg::PEN_WIDTH_BITS);
  endtask

  initial begin
    int items_sent, x1, y1, x2, y2, span, steps, adx, ady;
    rst = 1'b1;
    in_valid = 1'b0;
    begin_line = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 38;
    rx_idle_pct = 56;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // advance with no line, then a single point from reset values, then advance past it
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // corner of the coordinate range, widest pen, x major stepping down
    settle();
    program_line(-1024, 1023, -1020, 1021, 0, 16);
    send_item(1'b1);
    repeat (4) send_item(1'b0);

    // endpoints given in falling order, pen width zero
    settle();
    program_line(1023, -1024, 1020, -1024, 9, 0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // diagonal goes y major; oversized pen saturates; restart mid line
    settle();
    program_line(5, 5, 8, 2, 6, 31);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // ignored indexes, then pen and endpoint writes in the middle of a line
    settle();
    write_reg(REG_SPARE_LO, $urandom, wlr_pkg::CFG_DATA_BITS);
    write_reg(REG_SPARE_HI, $urandom, wlr_pkg::CFG_DATA_BITS);
    write_reg(wlr_pkg::REG_PEN_WIDTH, 17, wlr_pkg::PEN_WIDTH_BITS);
    send_item(1'b1);
    send_item(1'b0);
    settle();
    write_reg(wlr_pkg::REG_PEN_COLOR, 3, wlr_pkg::COLOR_BITS);
    write_reg(wlr_pkg::REG_PEN_WIDTH, 2, wlr_pkg::PEN_WIDTH_BITS);
    write_reg(wlr_pkg::REG_END_X, -700, COORD_BITS);
    send_item(1'b0);
    send_item(1'b0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 56;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 56;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      span = ($urandom_range(7) == 0) ? 40 : 10;
      x1 = int'($urandom_range(2047)) - 1024;
      y1 = int'($urandom_range(2047)) - 1024;
      x2 = x1 + int'($urandom_range(2 * span)) - span;
      y2 = y1 + int'($urandom_range(2 * span)) - span;
      if (x2 > 1023 || x2 < -1024) x2 = 2 * x1 - x2;
      if (y2 > 1023 || y2 < -1024) y2 = 2 * y1 - y2;
      adx = (x2 > x1) ? x2 - x1 : x1 - x2;
      ady = (y2 > y1) ? y2 - y1 : y1 - y2;
      // a few advances past the end exercise the no-line case
      steps = ((adx > ady) ? adx : ady) + int'($urandom_range(2));
      settle();
      program_line(x1, y1, x2, y2, $urandom_range(15), $urandom_range(31));
      send_item(1'b1);
      items_sent++;
      repeat (steps) begin
        if ($urandom_range(29) == 0) begin
          settle();
          write_reg(wlr_pkg::REG_PEN_COLOR, $urandom_range(15), wlr_pkg::COLOR_BITS);
          write_reg(wlr_pkg::REG_PEN_WIDTH, $urandom_range(31), wlr_pkg::PEN_WIDTH_BITS);
          write_reg(wlr_pkg::REG_END_Y, int'($urandom_range(2047)) - 1024, COORD_BITS);
        end
        send_item($urandom_range(19) == 0);
        items_sent++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (pixel_errors == 0 && pixels_outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
